// ----- sv/cdm_pkg.sv -----
package cdm_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = 6;
  localparam int N_W        = 7;
  localparam int COS_DEPTH  = 1024;
  localparam int ROM_AW     = 11;
  localparam int PH_W       = 12;
  localparam int DIV_NW     = 48;
  localparam int DIV_DW     = 33;
  localparam int DIV_CW     = 6;
  localparam int SUM_W      = 56;
  localparam logic [N_W-1:0] N_RESET = 7'd64;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef logic [30:0] cos_word_t;
  typedef cos_word_t cos_rom_t [0:COS_DEPTH];

  typedef struct packed {
    logic start;
    logic phase_start;
    logic phase_sel_j;
    logic rom_rd;
    logic latch_xi;
    logic latch_xj;
    logic main_start;
    logic acc_write;
    logic j_inc;
    logic j_clr;
    logic diag_write;
    logic buf_rd;
    logic out_load;
    logic out_bad;
  } cdm_cmd_t;

  typedef struct packed {
    logic bad_row;
    logic j_is_i;
    logic j_last;
    logic div_done;
    logic diff_zero;
    logic out_free;
  } cdm_stat_t;

  // Taylor series, terms divided by (2n-1)(2n) for n = 1..8
  function automatic cos_word_t cos_entry(input int m);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint sum;
    cos_word_t res;
    theta = (HALF_PI_Q30 * longint'(m) + 64'd512) >> 10;
    t2    = (theta * theta) >> 30;
    term  = ONE_Q30;
    sum   = longint'(ONE_Q30);
    term  = ((term * t2) >> 30) >> 1;
    sum   = sum - longint'(term);
    term  = ((term * t2) >> 30) / 64'd12;
    sum   = sum + longint'(term);
    term  = ((term * t2) >> 30) / 64'd30;
    sum   = sum - longint'(term);
    term  = ((term * t2) >> 30) / 64'd56;
    sum   = sum + longint'(term);
    term  = ((term * t2) >> 30) / 64'd90;
    sum   = sum - longint'(term);
    term  = ((term * t2) >> 30) / 64'd132;
    sum   = sum + longint'(term);
    term  = ((term * t2) >> 30) / 64'd182;
    sum   = sum - longint'(term);
    term  = ((term * t2) >> 30) / 64'd240;
    sum   = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    res = cos_word_t'(sum);
    if (m >= COS_DEPTH) begin
      res = '0;
    end
    return res;
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t t;
    for (int m = 0; m <= COS_DEPTH; m++) begin
      t[m] = cos_entry(m);
    end
    return t;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ----- sv/cdm_div.sv -----
module cdm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cdm_pkg::DIV_NW-1:0] num,
  input  logic [cdm_pkg::DIV_DW-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [cdm_pkg::DIV_NW-1:0] quo
);
  import cdm_pkg::*;

  logic [DIV_NW-1:0] num_r, num_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   trial;

  assign trial = {rem_r, num_r[DIV_NW-1]};

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = DIV_CW'(DIV_NW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- sv/cdm_datapath.sv -----
module cdm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cdm_pkg::cdm_cmd_t            cmd,
  output cdm_pkg::cdm_stat_t           stat,
  input  logic                         cfg_we,
  input  logic [cdm_pkg::N_W-1:0]      cfg_wdata,
  input  logic [cdm_pkg::IDX_W-1:0]    in_row_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cdm_pkg::IDX_W-1:0]    out_column_index,
  output logic signed [31:0]           out_entry_value,
  output logic                         out_saturated,
  output logic                         out_bad_row,
  output logic                         out_last_of_row
);
  import cdm_pkg::*;

  logic [N_W-1:0]    ncfg_r;
  logic [N_W-1:0]    n_r;
  logic [N_W-1:0]    n_eff;
  logic [N_W-1:0]    nm1;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  k_sel;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] div_q;

  logic [PH_W-1:0]   p_cl;
  logic [ROM_AW-1:0] rom_addr_r;
  logic              rom_neg_r;
  cos_word_t         rom_q_r;
  logic signed [31:0] x_cur;
  logic signed [31:0] xi_r;
  logic signed [31:0] xj_r;

  logic signed [32:0] diff;
  logic [32:0]        mag_full;
  logic [31:0]        mag;
  logic               mi_two;
  logic               mj_two;
  logic [DIV_DW-1:0]  den_main;
  logic [DIV_NW-1:0]  num_main;
  logic               v_neg;
  logic [DIV_NW-1:0]  qv;
  logic signed [DIV_NW:0] v;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W:0]   neg_sum;
  logic signed [SUM_W:0]   clip_in;
  logic [32:0]        clip_word;

  logic [32:0]        buf_mem [0:MAX_POINTS-1];
  logic [32:0]        buf_q_r;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_col_r;
  logic [31:0]        out_val_r;
  logic               out_sat_r;
  logic               out_bad_r;
  logic               out_last_r;
  logic               out_free;

  always_comb begin
    n_eff = ncfg_r;
    if (ncfg_r < N_W'(2)) begin
      n_eff = N_W'(2);
    end else if (ncfg_r > N_W'(MAX_POINTS)) begin
      n_eff = N_W'(MAX_POINTS);
    end
  end

  assign nm1   = n_r - 1'b1;
  assign k_sel = cmd.phase_sel_j ? j_r : i_r;

  always_comb begin
    if (cmd.main_start) begin
      div_num = num_main;
      div_den = den_main;
    end else begin
      div_num = DIV_NW'({k_sel, 11'b0}) + DIV_NW'(nm1[N_W-1:1]);
      div_den = DIV_DW'(nm1);
    end
  end

  assign div_start = cmd.phase_start | cmd.main_start;

  cdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign p_cl = (div_q > DIV_NW'(2 * COS_DEPTH)) ? PH_W'(2 * COS_DEPTH) : div_q[PH_W-1:0];

  assign x_cur = rom_neg_r ? -$signed({1'b0, rom_q_r}) : $signed({1'b0, rom_q_r});

  assign diff     = $signed({xi_r[31], xi_r}) - $signed({xj_r[31], xj_r});
  assign mag_full = diff[32] ? 33'(-diff) : 33'(diff);
  assign mag      = mag_full[31:0];
  assign mi_two   = (i_r == '0) || ({1'b0, i_r} == nm1);
  assign mj_two   = (j_r == '0) || ({1'b0, j_r} == nm1);
  assign den_main = mj_two ? {mag, 1'b0} : {1'b0, mag};
  assign num_main = (mi_two ? (DIV_NW'(1) << 47) : (DIV_NW'(1) << 46))
                    + DIV_NW'(den_main[DIV_DW-1:1]);
  assign v_neg    = i_r[0] ^ j_r[0] ^ diff[32];
  assign qv       = (diff == '0) ? (DIV_NW'(1) << 31) : div_q;
  assign v        = v_neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
  assign neg_sum  = -$signed({sum_r[SUM_W-1], sum_r});

  assign clip_in  = cmd.diag_write ? neg_sum : (SUM_W+1)'(v);

  always_comb begin
    if (clip_in > $signed((SUM_W+1)'(64'sd2147483647))) begin
      clip_word = {1'b1, 32'h7FFF_FFFF};
    end else if (clip_in < $signed(-(SUM_W+1)'(64'sd2147483648))) begin
      clip_word = {1'b1, 32'h8000_0000};
    end else begin
      clip_word = {1'b0, clip_in[31:0]};
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncfg_r <= N_RESET;
    end else if (cfg_we) begin
      ncfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r <= n_eff;
      i_r <= in_row_index;
    end
    if (cmd.start || cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j_r + 1'b1;
    end
    if (cmd.rom_rd) begin
      if (p_cl <= PH_W'(COS_DEPTH)) begin
        rom_addr_r <= p_cl[ROM_AW-1:0];
        rom_neg_r  <= 1'b0;
      end else begin
        rom_addr_r <= ROM_AW'(PH_W'(2 * COS_DEPTH) - p_cl);
        rom_neg_r  <= 1'b1;
      end
    end
    rom_q_r <= COS_ROM[rom_addr_r];
    if (cmd.latch_xi) begin
      xi_r <= x_cur;
    end
    if (cmd.latch_xj) begin
      xj_r <= x_cur;
    end
    if (cmd.start) begin
      sum_r <= '0;
    end else if (cmd.acc_write) begin
      sum_r <= sum_r + SUM_W'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_write) begin
      buf_mem[j_r] <= clip_word;
    end else if (cmd.diag_write) begin
      buf_mem[i_r] <= clip_word;
    end
    if (cmd.buf_rd) begin
      buf_q_r <= buf_mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.out_bad) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_bad) begin
      out_col_r  <= '0;
      out_val_r  <= '0;
      out_sat_r  <= 1'b0;
      out_bad_r  <= 1'b1;
      out_last_r <= 1'b1;
    end else if (cmd.out_load) begin
      out_col_r  <= j_r;
      out_val_r  <= buf_q_r[31:0];
      out_sat_r  <= buf_q_r[32];
      out_bad_r  <= 1'b0;
      out_last_r <= ({1'b0, j_r} == nm1);
    end
  end

  assign stat.bad_row   = ({1'b0, i_r} >= n_r);
  assign stat.j_is_i    = (j_r == i_r);
  assign stat.j_last    = ({1'b0, j_r} == nm1);
  assign stat.div_done  = div_done;
  assign stat.diff_zero = (diff == '0);
  assign stat.out_free  = out_free;

  assign out_valid        = out_valid_r;
  assign out_column_index = out_col_r;
  assign out_entry_value  = out_val_r;
  assign out_saturated    = out_sat_r;
  assign out_bad_row      = out_bad_r;
  assign out_last_of_row  = out_last_r;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load || cmd.out_bad) |-> out_free)
    else $error("output register overwritten");

  a_acc_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_write && (diff != '0)) |-> div_done)
    else $error("quotient used before division finished");

endmodule

// ----- sv/cdm_ctrl.sv -----
module cdm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cdm_pkg::cdm_stat_t  stat,
  output cdm_pkg::cdm_cmd_t   cmd
);
  import cdm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_BAD   = 4'd2;
  localparam logic [3:0] S_PH_I  = 4'd3;
  localparam logic [3:0] S_ROM_I = 4'd4;
  localparam logic [3:0] S_XI    = 4'd5;
  localparam logic [3:0] S_JCHK  = 4'd6;
  localparam logic [3:0] S_PH_J  = 4'd7;
  localparam logic [3:0] S_ROM_J = 4'd8;
  localparam logic [3:0] S_XJ    = 4'd9;
  localparam logic [3:0] S_MST   = 4'd10;
  localparam logic [3:0] S_DIVM  = 4'd11;
  localparam logic [3:0] S_DIAG  = 4'd12;
  localparam logic [3:0] S_ORD   = 4'd13;
  localparam logic [3:0] S_OWAIT = 4'd14;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.bad_row) begin
          state_nxt = S_BAD;
        end else begin
          cmd.phase_start = 1'b1;
          state_nxt       = S_PH_I;
        end
      end
      S_BAD: begin
        if (stat.out_free) begin
          cmd.out_bad = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_PH_I: begin
        if (stat.div_done) begin
          cmd.rom_rd = 1'b1;
          state_nxt  = S_ROM_I;
        end
      end
      S_ROM_I: state_nxt = S_XI;
      S_XI: begin
        cmd.latch_xi = 1'b1;
        state_nxt    = S_JCHK;
      end
      S_JCHK: begin
        if (stat.j_is_i) begin
          if (stat.j_last) begin
            state_nxt = S_DIAG;
          end else begin
            cmd.j_inc = 1'b1;
          end
        end else begin
          cmd.phase_start = 1'b1;
          cmd.phase_sel_j = 1'b1;
          state_nxt       = S_PH_J;
        end
      end
      S_PH_J: begin
        if (stat.div_done) begin
          cmd.rom_rd = 1'b1;
          state_nxt  = S_ROM_J;
        end
      end
      S_ROM_J: state_nxt = S_XJ;
      S_XJ: begin
        cmd.latch_xj = 1'b1;
        state_nxt    = S_MST;
      end
      S_MST: begin
        if (stat.diff_zero) begin
          cmd.acc_write = 1'b1;
          if (stat.j_last) begin
            state_nxt = S_DIAG;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_JCHK;
          end
        end else begin
          cmd.main_start = 1'b1;
          state_nxt      = S_DIVM;
        end
      end
      S_DIVM: begin
        if (stat.div_done) begin
          cmd.acc_write = 1'b1;
          if (stat.j_last) begin
            state_nxt = S_DIAG;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_JCHK;
          end
        end
      end
      S_DIAG: begin
        cmd.diag_write = 1'b1;
        cmd.j_clr      = 1'b1;
        state_nxt      = S_ORD;
      end
      S_ORD: begin
        cmd.buf_rd = 1'b1;
        state_nxt  = S_OWAIT;
      end
      S_OWAIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.j_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (in_valid && !in_stall))
    else $error("row started without a transaction");

  a_diag_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.diag_write |=> cmd.buf_rd)
    else $error("readout did not follow diagonal write");

  a_one_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.phase_start && cmd.main_start))
    else $error("two divider starts at once");

endmodule

// ----- sv/chebyshev_diff_matrix_row_top.sv -----
// Chebyshev differentiation matrix, one row per input transaction.
// Input channel: in_row_index with in_valid/in_stall. Output channel:
// one transaction per column (out_column_index 0 first) with
// out_entry_value (signed Q16.16), out_saturated, out_bad_row and
// out_last_of_row marking the final transaction of the row.
// cfg_we/cfg_wdata set the node count N (reset 64, clamped to 2..64);
// write it only while the block is idle.
// One row at a time: in_stall is high from acceptance until the last
// column has been loaded into the output register.
// One shared 48-step restoring divider serves the node phase and each
// quotient: one division for the node of the row, two per off-diagonal
// column (one when the nodes coincide); then each column is read out
// of the row buffer and emitted in turn.
// A row index of N or more gives one flagged transaction, issued once
// the output register is free.
// Reset (rst_n, synchronous) idles the controller and empties the
// output register. A stall on the output holds the current result and
// pauses readout; no result is dropped.
module chebyshev_diff_matrix_row_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [cdm_pkg::N_W-1:0]    cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cdm_pkg::IDX_W-1:0]  in_row_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cdm_pkg::IDX_W-1:0]  out_column_index,
  output logic signed [31:0]         out_entry_value,
  output logic                       out_saturated,
  output logic                       out_bad_row,
  output logic                       out_last_of_row
);
  import cdm_pkg::*;

  cdm_cmd_t  cmd;
  cdm_stat_t stat;

  cdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdm_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_row_index     (in_row_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_index (out_column_index),
    .out_entry_value  (out_entry_value),
    .out_saturated    (out_saturated),
    .out_bad_row      (out_bad_row),
    .out_last_of_row  (out_last_of_row)
  );

endmodule
